@@ hdl/utgu_pkg.sv @@
// Shared types, constants and code point functions for the Greek uppercase transcoder.
// Used by utgu_front, utgu_fifo, utgu_back and the top level; depends on nothing.
package utgu_pkg;

  localparam int QueueDepthDefault = 4;
  localparam int CpW = 21;

  // One queue entry: an optional flush of an open sequence, then an optional code point
  typedef struct packed {
    logic           flush;
    logic [7:0]     flush_lead;
    logic [1:0]     flush_cnt;
    logic [5:0]     flush_p0;
    logic [5:0]     flush_p1;
    logic           tail;
    logic [CpW-1:0] tail_cp;
    logic           last;
  } cmd_t;

  // Raise a Greek or ASCII code point to uppercase; any other code point passes unchanged
  function automatic logic [CpW-1:0] to_upper(input logic [CpW-1:0] cp);
    logic [CpW-1:0] up;
    up = cp;
    priority if ((cp >= 21'h03B1 && cp <= 21'h03C1) || (cp >= 21'h03C3 && cp <= 21'h03C9)) begin
      up = cp - 21'h20;
    end else if (cp == 21'h03C2) begin
      up = 21'h03A3;
    end else if (cp == 21'h03AC) begin
      up = 21'h0391;
    end else if (cp == 21'h03AD) begin
      up = 21'h0395;
    end else if (cp == 21'h03AE) begin
      up = 21'h0397;
    end else if (cp == 21'h03AF || cp == 21'h0390 || cp == 21'h03CA) begin
      up = 21'h0399;
    end else if (cp == 21'h03CC) begin
      up = 21'h039F;
    end else if (cp == 21'h03CD || cp == 21'h03CB || cp == 21'h03B0) begin
      up = 21'h03A5;
    end else if (cp == 21'h03CE) begin
      up = 21'h03A9;
    end else if (cp >= 21'h61 && cp <= 21'h7A) begin
      up = cp - 21'h20;
    end else begin
      up = cp;
    end
    return up;
  endfunction

  // Index of the final UTF-8 byte of a code point (length minus one)
  function automatic logic [1:0] enc_last(input logic [CpW-1:0] cp);
    logic [1:0] n;
    priority if (cp <= 21'h7F) begin
      n = 2'd0;
    end else if (cp <= 21'h7FF) begin
      n = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // One UTF-8 byte of a code point, counted from the lead byte
  function automatic logic [7:0] enc_byte(input logic [CpW-1:0] cp, input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (enc_last(cp))
      2'd0: b = cp[7:0];
      2'd1: begin
        unique case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

@@ hdl/utgu_front.sv @@
// Front end: takes input bytes, tracks the open UTF-8 sequence and builds queue entries.
// Depends on utgu_pkg for cmd_t.
module utgu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             last_in,
  output logic             cmd_push,
  output utgu_pkg::cmd_t   cmd
);
  import utgu_pkg::*;

  logic [7:0] lead, lead_next;
  logic [1:0] need, need_next;
  logic [1:0] held, held_next;
  logic [5:0] p0, p0_next;
  logic [5:0] p1, p1_next;
  logic       is_cont;
  logic       complete;
  logic [1:0] open_need;

  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign complete = ({1'b0, held} + 3'd1) >= {1'b0, need};

  // Number of continuation bytes announced by a lead byte, zero for anything else
  always_comb begin
    priority if (in_byte[7:5] == 3'b110) begin
      open_need = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      open_need = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      open_need = 2'd3;
    end else begin
      open_need = 2'd0;
    end
  end

  // Classify the byte and work out the entry and the next sequence state
  always_comb begin
    lead_next = lead;
    need_next = need;
    held_next = held;
    p0_next   = p0;
    p1_next   = p1;
    cmd       = '0;
    cmd.last  = last_in;
    if (need != 2'd0 && is_cont) begin
      if (complete) begin
        cmd.tail = 1'b1;
        unique case (need)
          2'd1:    cmd.tail_cp = {10'b0, lead[4:0], in_byte[5:0]};
          2'd2:    cmd.tail_cp = {5'b0, lead[3:0], p0, in_byte[5:0]};
          default: cmd.tail_cp = {lead[2:0], p0, p1, in_byte[5:0]};
        endcase
        need_next = 2'd0;
        held_next = 2'd0;
      end else begin
        if (held[0]) begin
          p1_next = in_byte[5:0];
        end else begin
          p0_next = in_byte[5:0];
        end
        held_next = held + 2'd1;
        // flush the extended sequence at the end of the string
        if (last_in) begin
          cmd.flush      = 1'b1;
          cmd.flush_lead = lead;
          cmd.flush_cnt  = held_next;
          cmd.flush_p0   = p0_next;
          cmd.flush_p1   = p1_next;
          need_next      = 2'd0;
          held_next      = 2'd0;
        end
      end
    end else begin
      // flush a broken sequence as separate code points
      if (need != 2'd0) begin
        cmd.flush      = 1'b1;
        cmd.flush_lead = lead;
        cmd.flush_cnt  = held;
        cmd.flush_p0   = p0;
        cmd.flush_p1   = p1;
        need_next      = 2'd0;
        held_next      = 2'd0;
      end
      if (open_need != 2'd0 && !last_in) begin
        lead_next = in_byte;
        need_next = open_need;
        held_next = 2'd0;
      end else begin
        // a plain byte, a stray byte, or a lead cut off by the end of the string
        cmd.tail    = 1'b1;
        cmd.tail_cp = {13'b0, in_byte};
      end
    end
  end

  assign cmd_push = accept && (cmd.flush || cmd.tail);

  // Hold the sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      need <= 2'd0;
      held <= 2'd0;
    end else if (accept) begin
      need <= need_next;
      held <= held_next;
    end
  end

  // Hold the lead byte and continuation payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      lead <= lead_next;
      p0   <= p0_next;
      p1   <= p1_next;
    end
  end

endmodule

@@ hdl/utgu_fifo.sv @@
// Short queue of entries between front and back end.
// Depends on utgu_pkg for cmd_t.
module utgu_fifo #(
  parameter int DEPTH = utgu_pkg::QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utgu_pkg::cmd_t   wdata,
  input  logic             pop,
  output utgu_pkg::cmd_t   rdata,
  output logic             full,
  output logic             empty
);
  import utgu_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/utgu_back.sv @@
// Back end: walks the code points of each entry, uppercases and re-encodes them as UTF-8,
// and holds one output byte in the output register. Depends on utgu_pkg.
module utgu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  utgu_pkg::cmd_t   head,
  output logic             head_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             item_done,
  output logic             string_done
);
  import utgu_pkg::*;

  localparam logic [1:0] SlotLead = 2'd0;
  localparam logic [1:0] SlotHeld0 = 2'd1;
  localparam logic [1:0] SlotHeld1 = 2'd2;
  localparam logic [1:0] SlotTail = 2'd3;

  logic [1:0]     seq;
  logic [1:0]     bidx;
  logic           out_valid;
  logic [3:0]     pres;
  logic [3:0]     avail;
  logic [3:0]     higher;
  logic [1:0]     cur;
  logic [1:0]     next_slot;
  logic           last_slot;
  logic [CpW-1:0] cp;
  logic [CpW-1:0] up;
  logic           last_byte;
  logic           advance;

  // Slots present in the head entry
  assign pres = {head.tail,
                 head.flush && (head.flush_cnt >= 2'd2),
                 head.flush && (head.flush_cnt != 2'd0),
                 head.flush};
  assign avail  = pres & (4'hF << seq);
  assign higher = pres & (4'hE << cur);
  assign last_slot = (higher == 4'h0);

  // Pick the current slot
  always_comb begin
    priority if (avail[0]) begin
      cur = SlotLead;
    end else if (avail[1]) begin
      cur = SlotHeld0;
    end else if (avail[2]) begin
      cur = SlotHeld1;
    end else begin
      cur = SlotTail;
    end
  end

  // Pick the slot after it
  always_comb begin
    priority if (higher[1]) begin
      next_slot = SlotHeld0;
    end else if (higher[2]) begin
      next_slot = SlotHeld1;
    end else begin
      next_slot = SlotTail;
    end
  end

  // Select, uppercase and encode the code point
  always_comb begin
    unique case (cur)
      SlotLead:  cp = {13'b0, head.flush_lead};
      SlotHeld0: cp = {13'b0, 2'b10, head.flush_p0};
      SlotHeld1: cp = {13'b0, 2'b10, head.flush_p1};
      default:   cp = head.tail_cp;
    endcase
  end

  assign up        = to_upper(cp);
  assign last_byte = (bidx == enc_last(up));
  assign advance   = head_valid && (!out_valid || pop);
  assign head_pop  = advance && last_byte && last_slot;
  assign empty     = !out_valid;

  // Step through bytes and slots
  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SlotLead;
      bidx      <= 2'd0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      if (last_byte) begin
        bidx <= 2'd0;
        seq  <= last_slot ? SlotLead : next_slot;
      end else begin
        bidx <= bidx + 2'd1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= enc_byte(up, bidx);
      item_done   <= last_byte && last_slot;
      string_done <= last_byte && last_slot && head.last;
    end
  end

endmodule

@@ hdl/utf8_greek_uppercase_transcoder.sv @@
// Top level of the UTF-8 Greek uppercase transcoder.
// Depends on utgu_pkg, utgu_front, utgu_fifo and utgu_back.
//
// Takes one UTF-8 byte per cycle and returns the uppercased UTF-8 bytes, one per cycle,
// through a queue-style port on each side. The front end accepts a byte in every cycle
// that the entry queue (QUEUE_DEPTH entries) has room; the back end emits one output byte
// per cycle while its output register is empty or popped, so an input byte that yields
// 1 to 8 output bytes holds the back end until all are out, and a byte that only opens or
// extends a sequence yields none. The first output byte of an item passes the entry queue
// and the output register. A broken or unfinished sequence comes out as its lead and
// continuation bytes, each as a code point of its own, ahead of the byte that broke it.
module utf8_greek_uppercase_transcoder #(
  parameter int QUEUE_DEPTH = utgu_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       last_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       item_done,
  output logic       string_done
);
  import utgu_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic cmd_push;
  logic q_empty;
  logic head_pop;

  utgu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (push && !full),
    .in_byte  (in_byte),
    .last_in  (last_in),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  utgu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd),
    .pop   (head_pop),
    .rdata (head),
    .full  (full),
    .empty (q_empty)
  );

  utgu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!q_empty),
    .head        (head),
    .head_pop    (head_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .item_done   (item_done),
    .string_done (string_done)
  );

endmodule

@@ test/tb_utf8_greek_uppercase_transcoder.sv @@
// Testbench for utf8_greek_uppercase_transcoder: directed and random UTF-8 strings.
// Needs only the transcoder RTL; its own case mapper and UTF-8 encoder predict every
// output byte, which a free-running process compares with the block's output queue.
`timescale 1ns / 100ps

module tb_utf8_greek_uppercase_transcoder;

  localparam int CycleLimit = 400000;
  localparam int MaxGap     = 17;
  localparam int DrainTail  = 24;

  typedef logic [7:0] octet_t;

  // One expected output item
  typedef struct packed {
    logic [7:0] data;
    logic       idone;
    logic       sdone;
  } out_item_t;

  // One UTF-8 encoding, lead byte at index 0
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_seq_t;

  logic       clk     = 1'b0;
  logic       rst     = 1'b1;
  logic       push    = 1'b0;
  logic       pop     = 1'b0;
  logic [7:0] in_byte = 8'h01;
  logic       last_in = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       item_done;
  logic       string_done;

  // Predictor state: open sequence, held continuation payloads
  logic [7:0] lead_r = 8'h00;
  logic [1:0] need_r = 2'd0;
  logic [1:0] held_r = 2'd0;
  logic [5:0] pay_r [2];

  out_item_t  upper_bytes_q [$];
  octet_t     step_bytes [$];
  octet_t     text_bytes [$];
  int         errors = 0;
  int         cycles = 0;
  bit         steady = 1'b0;

  utf8_greek_uppercase_transcoder DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .last_in     (last_in),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .item_done   (item_done),
    .string_done (string_done)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("utf8_greek_uppercase_transcoder test failed");
      $finish;
    end
  end

  // Greek and ASCII uppercase mapping on code points
  function automatic logic [20:0] raise_case(input logic [20:0] cp);
    logic [20:0] up;
    up = cp;
    if ((cp >= 21'h03B1 && cp <= 21'h03C1) || (cp >= 21'h03C3 && cp <= 21'h03C9)) begin
      up = cp - 21'h20;
    end else if (cp >= 21'h61 && cp <= 21'h7A) begin
      up = cp - 21'h20;
    end else begin
      case (cp)
        21'h03C2: up = 21'h03A3;
        21'h03AC: up = 21'h0391;
        21'h03AD: up = 21'h0395;
        21'h03AE: up = 21'h0397;
        21'h03AF, 21'h0390, 21'h03CA: up = 21'h0399;
        21'h03CC: up = 21'h039F;
        21'h03CD, 21'h03CB, 21'h03B0: up = 21'h03A5;
        21'h03CE: up = 21'h03A9;
        default:  up = cp;
      endcase
    end
    return up;
  endfunction

  function automatic utf8_seq_t encode_utf8(input logic [20:0] cp);
    utf8_seq_t s;
    s.b = '0;
    if (cp <= 21'h7F) begin
      s.len  = 3'd1;
      s.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      s.len  = 3'd2;
      s.b[0] = {3'b110, cp[10:6]};
      s.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      s.len  = 3'd3;
      s.b[0] = {4'b1110, cp[15:12]};
      s.b[1] = {2'b10, cp[11:6]};
      s.b[2] = {2'b10, cp[5:0]};
    end else begin
      s.len  = 3'd4;
      s.b[0] = {5'b11110, cp[20:18]};
      s.b[1] = {2'b10, cp[17:12]};
      s.b[2] = {2'b10, cp[11:6]};
      s.b[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

  // Append the uppercased encoding of one code point to the step buffer
  task automatic emit_code_point(input logic [20:0] cp);
    utf8_seq_t s;
    s = encode_utf8(raise_case(cp));
    for (int k = 0; k < s.len; k++) step_bytes.push_back(s.b[k]);
  endtask

  // Emit the open lead and held continuations as code points of their own
  task automatic flush_open();
    emit_code_point({13'd0, lead_r});
    for (int k = 0; k < held_r; k++) emit_code_point({13'd0, 2'b10, pay_r[k]});
    need_r = 2'd0;
    held_r = 2'd0;
  endtask

  // Advance the predictor by one accepted byte and queue its output items
  task automatic transcode_byte(input logic [7:0] b, input logic last);
    logic [20:0] cp;
    out_item_t   it;
    step_bytes.delete();
    if (need_r != 2'd0 && b[7:6] == 2'b10) begin
      if (int'(held_r) + 1 >= int'(need_r)) begin
        case (need_r)
          2'd1:    cp = {10'd0, lead_r[4:0], b[5:0]};
          2'd2:    cp = {5'd0, lead_r[3:0], pay_r[0], b[5:0]};
          default: cp = {lead_r[2:0], pay_r[0], pay_r[1], b[5:0]};
        endcase
        emit_code_point(cp);
        need_r = 2'd0;
        held_r = 2'd0;
      end else begin
        pay_r[held_r[0]] = b[5:0];
        held_r = held_r + 2'd1;
      end
    end else begin
      if (need_r != 2'd0) flush_open();
      if (b[7] == 1'b0) begin
        emit_code_point({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
        lead_r = b;
        need_r = 2'd1;
        held_r = 2'd0;
      end else if (b[7:4] == 4'b1110) begin
        lead_r = b;
        need_r = 2'd2;
        held_r = 2'd0;
      end else if (b[7:3] == 5'b11110) begin
        lead_r = b;
        need_r = 2'd3;
        held_r = 2'd0;
      end else begin
        emit_code_point({13'd0, b});
      end
    end
    if (last && need_r != 2'd0) flush_open();
    foreach (step_bytes[k]) begin
      it.data  = step_bytes[k];
      it.idone = (k == step_bytes.size() - 1);
      it.sdone = it.idone && last;
      upper_bytes_q.push_back(it);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("cycle %0d: %s mismatch, got %02h, expected %02h", cycles, what, got, want);
    errors++;
  endtask

  // Send one item after a random gap; hold push high into the next item
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MaxGap);
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    last_in <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    transcode_byte(b, last);
  endtask

  task automatic send_string();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // Stop sending and wait until every expected item has come out
  task automatic wait_drained();
    push <= 1'b0;
    while (upper_bytes_q.size() != 0) @(posedge clk);
  endtask

  // Build a string of mostly well-formed characters with broken ones and noise mixed in
  task automatic build_random_string();
    int          nchars;
    int          kind;
    int          keep;
    logic [20:0] cp;
    utf8_seq_t   s;
    text_bytes.delete();
    nchars = $urandom_range(1, 10);
    repeat (nchars) begin
      kind = $urandom_range(0, 99);
      if (kind >= 97) begin
        text_bytes.push_back(octet_t'($urandom_range(1, 255)));
      end else begin
        if (kind < 25)      cp = 21'($urandom_range(1, 21'h7F));
        else if (kind < 55) cp = 21'($urandom_range(21'h0370, 21'h03FF));
        else if (kind < 70) cp = 21'($urandom_range(21'h80, 21'h7FF));
        else if (kind < 82) cp = 21'($urandom_range(21'h800, 21'hFFFF));
        else if (kind < 90) cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
        else if ($urandom_range(0, 1) == 0) cp = 21'($urandom_range(21'h0370, 21'h03FF));
        else cp = 21'($urandom_range(21'h800, 21'h1FFFFF));
        s = encode_utf8(cp);
        // Cut a multi-byte character short for the broken kinds
        keep = (kind >= 90) ? $urandom_range(1, s.len - 1) : s.len;
        for (int k = 0; k < keep; k++) text_bytes.push_back(s.b[k]);
      end
    end
  endtask

  task automatic test_ascii();
    send_byte(8'h01, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_greek();
    send_byte(8'hCE, 1'b0);  // small alpha
    send_byte(8'hB1, 1'b0);
    send_byte(8'hCF, 1'b0);  // final sigma
    send_byte(8'h82, 1'b0);
    send_byte(8'hCE, 1'b0);  // alpha with tonos
    send_byte(8'hAC, 1'b0);
    send_byte(8'hCE, 1'b0);  // iota with diaeresis and tonos
    send_byte(8'h90, 1'b1);
  endtask

  task automatic test_long_forms();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // Lead interrupted by a fresh byte, with and without held continuations
  task automatic test_broken();
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_stray();
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b1);
  endtask

  // Sequences cut off by the end of the string
  task automatic test_unfinished();
    send_byte(8'hC3, 1'b1);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_random_text(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      build_random_string();
      send_string();
      sent += text_bytes.size();
    end
  endtask

  task automatic test_random_noise(input int n);
    repeat (n) send_byte(octet_t'($urandom_range(1, 255)), $urandom_range(0, 9) == 0);
  endtask

  // Hold the sender until the output side has caught up, then resume
  task automatic test_drain_pause();
    build_random_string();
    send_string();
    wait_drained();
    build_random_string();
    send_string();
  endtask

  // Compare each popped item with the oldest expectation
  initial begin : result_check
    out_item_t want;
    int        stall;
    wait (!rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MaxGap);
      repeat (stall) begin
        pop <= 1'b0;
        @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (upper_bytes_q.size() == 0) begin
        report_mismatch("unexpected item", out_byte, 8'h00);
      end else begin
        want = upper_bytes_q.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (item_done !== want.idone) begin
          report_mismatch("item_done", 8'(item_done), 8'(want.idone));
        end
        if (string_done !== want.sdone) begin
          report_mismatch("string_done", 8'(string_done), 8'(want.sdone));
        end
      end
    end
  end

  initial begin : run_tests
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_ascii();
    test_greek();
    test_long_forms();
    test_broken();
    test_stray();
    test_unfinished();
    test_random_text(60);
    test_drain_pause();
    steady = 1'b1;
    test_random_text(30);
    steady = 1'b0;
    test_random_noise(20);
    push <= 1'b0;
    wait_drained();
    repeat (DrainTail) @(posedge clk);
    if (errors == 0 && upper_bytes_q.size() == 0) begin
      $display("utf8_greek_uppercase_transcoder test passed");
    end else begin
      $display("%0d mismatches, %0d items still expected", errors, upper_bytes_q.size());
      $display("utf8_greek_uppercase_transcoder test failed");
    end
    $finish;
  end

endmodule
